// ===== design/depth_reprojection_jacobian_top_macros.svh =====
// ============================================================================
// Assertion macros for the depth reprojection block
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ============================================================================
`ifndef DEPTH_REPROJECTION_JACOBIAN_TOP_MACROS_SVH
`define DEPTH_REPROJECTION_JACOBIAN_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DRJ_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pipeline check failed");
`define DRJ_ASSERT_SAME(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pipeline check failed");
`else
`define DRJ_ASSERT_NEXT(name, ck, rs, ante, cons)
`define DRJ_ASSERT_SAME(name, ck, rs, ante, cons)
`endif

`endif

// ===== design/drj_pkg.sv =====
// ============================================================================
// Depth reprojection package
// Shared types, register codes and saturating fixed-point helpers.
// ============================================================================
package drj_pkg;

  typedef logic signed [63:0] s64_t;
  typedef logic [2:0] reg_idx_t;

  typedef struct packed {
    logic f;
    logic signed [63:0] v;
  } sres_t;

  typedef struct packed {
    logic f;
    logic signed [31:0] v;
  } o32_t;

  typedef struct packed {
    logic neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } mpp_t;

  typedef struct packed {
    logic neg;
    logic [63:0] hi;
    logic [63:0] lo;
  } mmx_t;

  localparam int ADDR_W = 6;

  localparam reg_idx_t REG_ROW0_LIN = 3'd0;
  localparam reg_idx_t REG_ROW0_OFF = 3'd1;
  localparam reg_idx_t REG_ROW1_LIN = 3'd2;
  localparam reg_idx_t REG_ROW1_OFF = 3'd3;
  localparam reg_idx_t REG_ROW2_LIN = 3'd4;
  localparam reg_idx_t REG_ROW2_OFF = 3'd5;
  localparam reg_idx_t REG_COUNT    = 3'd6;

  localparam int MUL_LAT   = 3;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int LAT       = 1 + MUL_LAT + 1 + MUL_LAT + 1 + DIV_LAT + MUL_LAT + 1 + DIV_LAT + 1;

  localparam int LANES_A = 6;
  localparam int LANES_B = 15;
  localparam int LANES_C = 4;

  localparam logic [63:0] TOP64   = 64'h8000_0000_0000_0000;
  localparam s64_t        S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam s64_t        S64_MIN = 64'sh8000_0000_0000_0000;

  function automatic s64_t sx(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  function automatic logic [63:0] mag64(input s64_t x);
    logic [63:0] ux;
    ux = x;
    return x[63] ? (64'd0 - ux) : ux;
  endfunction

  function automatic sres_t from_mag(input logic neg, input logic [63:0] mag);
    logic [63:0] lim;
    logic [63:0] m;
    sres_t r;
    lim = neg ? TOP64 : (TOP64 - 64'd1);
    m = mag;
    r.f = 1'b0;
    if (m > lim) begin
      r.f = 1'b1;
      m = lim;
    end
    r.v = neg ? (64'd0 - m) : m;
    return r;
  endfunction

  function automatic sres_t sadd(input s64_t x, input s64_t y);
    logic [64:0] s;
    sres_t r;
    s = {x[63], x} + {y[63], y};
    r.f = s[64] ^ s[63];
    r.v = r.f ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sres_t ssub(input s64_t x, input s64_t y);
    logic [64:0] s;
    sres_t r;
    s = {x[63], x} - {y[63], y};
    r.f = s[64] ^ s[63];
    r.v = r.f ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic mpp_t mul_pp(input s64_t x, input s64_t y);
    logic [63:0] ux;
    logic [63:0] uy;
    mpp_t r;
    ux = mag64(x);
    uy = mag64(y);
    r.neg = x[63] ^ y[63];
    r.p00 = {32'd0, ux[31:0]} * {32'd0, uy[31:0]};
    r.p01 = {32'd0, ux[31:0]} * {32'd0, uy[63:32]};
    r.p10 = {32'd0, ux[63:32]} * {32'd0, uy[31:0]};
    r.p11 = {32'd0, ux[63:32]} * {32'd0, uy[63:32]};
    return r;
  endfunction

  function automatic mmx_t mul_mix(input mpp_t p);
    logic [63:0] mid;
    mmx_t r;
    mid = {32'd0, p.p00[63:32]} + {32'd0, p.p01[31:0]} + {32'd0, p.p10[31:0]};
    r.neg = p.neg;
    r.lo = {mid[31:0], p.p00[31:0]};
    r.hi = p.p11 + {32'd0, p.p01[63:32]} + {32'd0, p.p10[63:32]} + {32'd0, mid[63:32]};
    return r;
  endfunction

  function automatic sres_t mul_fin(input mmx_t m, input int unsigned frac);
    logic [127:0] full;
    logic [63:0] mag;
    full = {m.hi, m.lo} >> frac;
    mag = ((m.hi >> frac) != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : full[63:0];
    return from_mag(m.neg, mag);
  endfunction

  function automatic o32_t out32(input s64_t x);
    logic fit;
    o32_t r;
    fit = (&x[63:31]) | ~(|x[63:31]);
    r.f = ~fit;
    r.v = fit ? x[31:0] : (x[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    return r;
  endfunction

endpackage

// ===== design/drj_if.sv =====
// ============================================================================
// Depth reprojection stream interfaces
// Pixel request channel and reprojection result channel.
// ============================================================================
interface drj_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pix_u;
  logic signed [31:0] pix_v;
  logic signed [31:0] depth;
  logic signed [31:0] depth_dx;
  logic signed [31:0] depth_dy;

  modport source (output valid, pix_u, pix_v, depth, depth_dx, depth_dy, input ready);
  modport sink (input valid, pix_u, pix_v, depth, depth_dx, depth_dy, output ready);
endinterface

interface drj_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] proj_x;
  logic signed [31:0] proj_y;
  logic signed [31:0] dx_du;
  logic signed [31:0] dy_du;
  logic signed [31:0] dx_dv;
  logic signed [31:0] dy_dv;
  logic               div_fault;

  modport source (output valid, proj_x, proj_y, dx_du, dy_du, dx_dv, dy_dv, div_fault,
                  input ready);
  modport sink (input valid, proj_x, proj_y, dx_du, dy_du, dx_dv, dy_dv, div_fault,
                output ready);
endinterface

// ===== design/drj_div.sv =====
// ============================================================================
// Pipelined fixed-point divider
// Restoring division of (num << FRAC_BITS) by den, one quotient bit per stage,
// with saturation and a zero-divisor fault.
// ============================================================================
module drj_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  drj_pkg::s64_t  num,
  input  drj_pkg::s64_t  den,
  output drj_pkg::sres_t quo
);

  localparam int STEPS = drj_pkg::DIV_STEPS;

  typedef struct packed {
    logic zero;
    logic nneg;
    logic neg;
    logic over;
  } dctl_t;

  logic [63:0] rem_q [0:STEPS-1];
  logic [63:0] ud_q  [0:STEPS-1];
  logic [63:0] sh_q  [0:STEPS];
  dctl_t       ctl_q [0:STEPS];

  logic [63:0] un;
  logic [63:0] ud;
  logic [63:0] nh;

  assign un = drj_pkg::mag64(num);
  assign ud = drj_pkg::mag64(den);
  assign nh = un >> (64 - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= nh;
      sh_q[0]  <= un << FRAC_BITS;
      ud_q[0]  <= ud;
      ctl_q[0] <= '{zero: (den == 64'sd0), nneg: num[63], neg: num[63] ^ den[63],
                    over: (nh >= ud)};
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [64:0] trial;
    logic        take;

    assign trial = {rem_q[k-1], sh_q[k-1][63]};
    assign take  = trial >= {1'b0, ud_q[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        sh_q[k]  <= {sh_q[k-1][62:0], take};
        ctl_q[k] <= ctl_q[k-1];
      end
    end

    if (k < STEPS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? 64'(trial - {1'b0, ud_q[k-1]}) : trial[63:0];
          ud_q[k]  <= ud_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_q[STEPS].zero) begin
        quo <= '{f: 1'b1, v: (ctl_q[STEPS].nneg ? drj_pkg::S64_MIN : drj_pkg::S64_MAX)};
      end else if (ctl_q[STEPS].over) begin
        quo <= drj_pkg::from_mag(ctl_q[STEPS].neg, 64'hFFFF_FFFF_FFFF_FFFF);
      end else begin
        quo <= drj_pkg::from_mag(ctl_q[STEPS].neg, sh_q[STEPS]);
      end
    end
  end

endmodule

// ===== design/depth_reprojection_jacobian_top.sv =====
// ============================================================================
// Depth reprojection with Jacobian: pipelined top level
// Accepts one request per cycle while the result channel is not stalled.
// Depth set mostly by two ranks of 66-stage bit-per-stage dividers and three ranks of 3-stage multipliers.
// rst clears the valid line and the six matrix registers to zero.
// ============================================================================
`include "depth_reprojection_jacobian_top_macros.svh"

module depth_reprojection_jacobian_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  drj_in_if.sink                      pix,
  drj_out_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drj_pkg::ADDR_W-1:0]  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);

  localparam int LAT  = drj_pkg::LAT;
  localparam int ML   = drj_pkg::MUL_LAT;
  localparam int DL   = drj_pkg::DIV_LAT;
  localparam int NA   = drj_pkg::LANES_A;
  localparam int NB   = drj_pkg::LANES_B;
  localparam int NC   = drj_pkg::LANES_C;

  typedef struct packed {
    drj_pkg::s64_t w;
    drj_pkg::s64_t wx;
    drj_pkg::s64_t wy;
  } wv_t;

  typedef struct packed {
    drj_pkg::s64_t gpu;
    drj_pkg::s64_t gqu;
    drj_pkg::s64_t gru;
    drj_pkg::s64_t gpv;
    drj_pkg::s64_t gqv;
    drj_pkg::s64_t grv;
    drj_pkg::s64_t d;
    logic          f;
  } c1_t;

  typedef struct packed {
    drj_pkg::s64_t x;
    drj_pkg::s64_t y;
    drj_pkg::s64_t gpu;
    drj_pkg::s64_t gqu;
    drj_pkg::s64_t gpv;
    drj_pkg::s64_t gqv;
    drj_pkg::s64_t d;
    logic          f;
  } c2_t;

  typedef struct packed {
    drj_pkg::s64_t x;
    drj_pkg::s64_t y;
    logic          f;
  } c3_t;

  logic [63:0]   cfg [0:5];
  drj_pkg::s64_t mat [0:2][0:2];
  drj_pkg::s64_t trn [0:2];
  logic [2:0]    widx;

  logic           en;
  logic           acc;
  logic [LAT-1:0] vld;

  assign widx   = paddr[drj_pkg::ADDR_W-1:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) cfg[i] <= '0;
    end else if (psel && penable && pwrite && (widx < drj_pkg::REG_COUNT)) begin
      cfg[widx] <= pwdata;
    end
  end

  always_comb begin
    unique case (widx)
      drj_pkg::REG_ROW0_LIN: prdata = cfg[drj_pkg::REG_ROW0_LIN];
      drj_pkg::REG_ROW0_OFF: prdata = cfg[drj_pkg::REG_ROW0_OFF];
      drj_pkg::REG_ROW1_LIN: prdata = cfg[drj_pkg::REG_ROW1_LIN];
      drj_pkg::REG_ROW1_OFF: prdata = cfg[drj_pkg::REG_ROW1_OFF];
      drj_pkg::REG_ROW2_LIN: prdata = cfg[drj_pkg::REG_ROW2_LIN];
      drj_pkg::REG_ROW2_OFF: prdata = cfg[drj_pkg::REG_ROW2_OFF];
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mat[i][0] = drj_pkg::sx(cfg[3'(2*i)][63:32]);
      mat[i][1] = drj_pkg::sx(cfg[3'(2*i)][31:0]);
      mat[i][2] = drj_pkg::sx(cfg[3'(2*i+1)][63:32]);
      trn[i]    = drj_pkg::sx(cfg[3'(2*i+1)][31:0]);
    end
  end

  assign en        = !vld[LAT-1] || res.ready;
  assign acc       = pix.valid && en;
  assign pix.ready = en;
  assign res.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], acc};
    end
  end

  drj_pkg::s64_t s0_u;
  drj_pkg::s64_t s0_v;
  wv_t           s0_wv;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_u  <= drj_pkg::sx(pix.pix_u);
      s0_v  <= drj_pkg::sx(pix.pix_v);
      s0_wv <= '{w: drj_pkg::sx(pix.depth), wx: drj_pkg::sx(pix.depth_dx),
                 wy: drj_pkg::sx(pix.depth_dy)};
    end
  end

  drj_pkg::s64_t  opa_x [0:NA-1];
  drj_pkg::s64_t  opa_y [0:NA-1];
  drj_pkg::mpp_t  a_pp  [0:NA-1];
  drj_pkg::mmx_t  a_mx  [0:NA-1];
  drj_pkg::sres_t a_fn  [0:NA-1];
  wv_t            la    [0:ML-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa_x[2*i]   = mat[i][0];
      opa_y[2*i]   = s0_u;
      opa_x[2*i+1] = mat[i][1];
      opa_y[2*i+1] = s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NA; k++) begin
        a_pp[k] <= drj_pkg::mul_pp(opa_x[k], opa_y[k]);
        a_mx[k] <= drj_pkg::mul_mix(a_pp[k]);
        a_fn[k] <= drj_pkg::mul_fin(a_mx[k], FRAC_BITS);
      end
      la[0] <= s0_wv;
      for (int k = 1; k < ML; k++) la[k] <= la[k-1];
    end
  end

  drj_pkg::sres_t sum1_a [0:2];
  drj_pkg::sres_t sum1_b [0:2];
  logic           sum1_f;
  drj_pkg::s64_t  s1_prq [0:2];
  wv_t            s1_wv;
  logic           s1_f;

  always_comb begin
    sum1_f = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum1_a[i] = drj_pkg::sadd(a_fn[2*i].v, a_fn[2*i+1].v);
      sum1_b[i] = drj_pkg::sadd(sum1_a[i].v, mat[i][2]);
      sum1_f = sum1_f | a_fn[2*i].f | a_fn[2*i+1].f | sum1_a[i].f | sum1_b[i].f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s1_prq[i] <= sum1_b[i].v;
      s1_wv <= la[ML-1];
      s1_f  <= sum1_f;
    end
  end

  drj_pkg::s64_t  opb_x [0:NB-1];
  drj_pkg::s64_t  opb_y [0:NB-1];
  drj_pkg::mpp_t  b_pp  [0:NB-1];
  drj_pkg::mmx_t  b_mx  [0:NB-1];
  drj_pkg::sres_t b_fn  [0:NB-1];
  logic           lb    [0:ML-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opb_x[i]    = s1_wv.w;
      opb_y[i]    = s1_prq[i];
      opb_x[3+i]  = s1_wv.wx;
      opb_y[3+i]  = s1_prq[i];
      opb_x[6+i]  = s1_wv.wy;
      opb_y[6+i]  = s1_prq[i];
      opb_x[9+i]  = s1_wv.w;
      opb_y[9+i]  = mat[i][0];
      opb_x[12+i] = s1_wv.w;
      opb_y[12+i] = mat[i][1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NB; k++) begin
        b_pp[k] <= drj_pkg::mul_pp(opb_x[k], opb_y[k]);
        b_mx[k] <= drj_pkg::mul_mix(b_pp[k]);
        b_fn[k] <= drj_pkg::mul_fin(b_mx[k], FRAC_BITS);
      end
      lb[0] <= s1_f;
      for (int k = 1; k < ML; k++) lb[k] <= lb[k-1];
    end
  end

  drj_pkg::sres_t sum2_abd [0:2];
  drj_pkg::sres_t sum2_gu  [0:2];
  drj_pkg::sres_t sum2_gv  [0:2];
  logic           sum2_f;
  drj_pkg::s64_t  s2_abd [0:2];
  drj_pkg::s64_t  s2_gu  [0:2];
  drj_pkg::s64_t  s2_gv  [0:2];
  logic           s2_f;

  always_comb begin
    sum2_f = lb[ML-1];
    for (int k = 0; k < NB; k++) sum2_f = sum2_f | b_fn[k].f;
    for (int i = 0; i < 3; i++) begin
      sum2_abd[i] = drj_pkg::sadd(b_fn[i].v, trn[i]);
      sum2_gu[i]  = drj_pkg::sadd(b_fn[3+i].v, b_fn[9+i].v);
      sum2_gv[i]  = drj_pkg::sadd(b_fn[6+i].v, b_fn[12+i].v);
      sum2_f = sum2_f | sum2_abd[i].f | sum2_gu[i].f | sum2_gv[i].f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_abd[i] <= sum2_abd[i].v;
        s2_gu[i]  <= sum2_gu[i].v;
        s2_gv[i]  <= sum2_gv[i].v;
      end
      s2_f <= sum2_f;
    end
  end

  drj_pkg::sres_t q1 [0:1];
  c1_t            l1 [0:DL-1];

  for (genvar k = 0; k < 2; k++) begin : g_div1
    drj_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (s2_abd[k]),
      .den (s2_abd[2]),
      .quo (q1[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1[0] <= '{gpu: s2_gu[0], gqu: s2_gu[1], gru: s2_gu[2], gpv: s2_gv[0], gqv: s2_gv[1],
                 grv: s2_gv[2], d: s2_abd[2], f: s2_f};
      for (int k = 1; k < DL; k++) l1[k] <= l1[k-1];
    end
  end

  drj_pkg::s64_t  opc_x [0:NC-1];
  drj_pkg::s64_t  opc_y [0:NC-1];
  drj_pkg::mpp_t  c_pp  [0:NC-1];
  drj_pkg::mmx_t  c_mx  [0:NC-1];
  drj_pkg::sres_t c_fn  [0:NC-1];
  c2_t            l2    [0:ML-1];

  always_comb begin
    opc_x[0] = q1[0].v;
    opc_y[0] = l1[DL-1].gru;
    opc_x[1] = q1[1].v;
    opc_y[1] = l1[DL-1].gru;
    opc_x[2] = q1[0].v;
    opc_y[2] = l1[DL-1].grv;
    opc_x[3] = q1[1].v;
    opc_y[3] = l1[DL-1].grv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NC; k++) begin
        c_pp[k] <= drj_pkg::mul_pp(opc_x[k], opc_y[k]);
        c_mx[k] <= drj_pkg::mul_mix(c_pp[k]);
        c_fn[k] <= drj_pkg::mul_fin(c_mx[k], FRAC_BITS);
      end
      l2[0] <= '{x: q1[0].v, y: q1[1].v, gpu: l1[DL-1].gpu, gqu: l1[DL-1].gqu,
                 gpv: l1[DL-1].gpv, gqv: l1[DL-1].gqv, d: l1[DL-1].d,
                 f: l1[DL-1].f | q1[0].f | q1[1].f};
      for (int k = 1; k < ML; k++) l2[k] <= l2[k-1];
    end
  end

  drj_pkg::sres_t sum3_n [0:NC-1];
  logic           sum3_f;
  drj_pkg::s64_t  s3_n   [0:NC-1];
  drj_pkg::s64_t  s3_d;
  c3_t            s3_c;

  always_comb begin
    sum3_n[0] = drj_pkg::ssub(l2[ML-1].gpu, c_fn[0].v);
    sum3_n[1] = drj_pkg::ssub(l2[ML-1].gqu, c_fn[1].v);
    sum3_n[2] = drj_pkg::ssub(l2[ML-1].gpv, c_fn[2].v);
    sum3_n[3] = drj_pkg::ssub(l2[ML-1].gqv, c_fn[3].v);
    sum3_f = l2[ML-1].f;
    for (int k = 0; k < NC; k++) sum3_f = sum3_f | c_fn[k].f | sum3_n[k].f;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NC; k++) s3_n[k] <= sum3_n[k].v;
      s3_d <= l2[ML-1].d;
      s3_c <= '{x: l2[ML-1].x, y: l2[ML-1].y, f: sum3_f};
    end
  end

  drj_pkg::sres_t q2 [0:NC-1];
  c3_t            l3 [0:DL-1];

  for (genvar k = 0; k < NC; k++) begin : g_div2
    drj_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (s3_n[k]),
      .den (s3_d),
      .quo (q2[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l3[0] <= s3_c;
      for (int k = 1; k < DL; k++) l3[k] <= l3[k-1];
    end
  end

  drj_pkg::o32_t o [0:5];
  logic          out_f;

  always_comb begin
    o[0] = drj_pkg::out32(l3[DL-1].x);
    o[1] = drj_pkg::out32(l3[DL-1].y);
    for (int k = 0; k < NC; k++) o[2+k] = drj_pkg::out32(q2[k].v);
    out_f = l3[DL-1].f;
    for (int k = 0; k < NC; k++) out_f = out_f | q2[k].f;
    for (int k = 0; k < 6; k++) out_f = out_f | o[k].f;
  end

  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_xu;
  logic signed [31:0] r_yu;
  logic signed [31:0] r_xv;
  logic signed [31:0] r_yv;
  logic               r_f;

  always_ff @(posedge clk) begin
    if (en) begin
      r_x  <= o[0].v;
      r_y  <= o[1].v;
      r_xu <= o[2].v;
      r_yu <= o[3].v;
      r_xv <= o[4].v;
      r_yv <= o[5].v;
      r_f  <= out_f;
    end
  end

  assign res.proj_x    = r_x;
  assign res.proj_y    = r_y;
  assign res.dx_du     = r_xu;
  assign res.dy_du     = r_yu;
  assign res.dx_dv     = r_xv;
  assign res.dy_dv     = r_yv;
  assign res.div_fault = r_f;

  `DRJ_ASSERT_NEXT(a_accept_enters, clk, rst, pix.valid && pix.ready, vld[0])
  `DRJ_ASSERT_NEXT(a_stall_holds, clk, rst, !en, $stable(vld))
  `DRJ_ASSERT_SAME(a_reset_empty, clk, rst, $fell(rst), vld == '0)

endmodule
